/* rtl/core/u8u16_pkg.sv */
package u8u16_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [20:0] CP_MIN2      = 21'h000080;
  localparam logic [20:0] CP_MIN3      = 21'h000800;
  localparam logic [20:0] CP_MIN4      = 21'h010000;
  localparam logic [20:0] CP_MAX       = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO    = 21'h00d800;
  localparam logic [20:0] CP_SUR_HI    = 21'h00dfff;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

  localparam logic [5:0] HI_SUR_TAG = 6'b110110;
  localparam logic [5:0] LO_SUR_TAG = 6'b110111;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        bad_sequence;
    logic        run_last;
    logic        text_done;
  } out_t;

  // one queue entry: all results caused by one byte
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/u8u16_front.sv */
module u8u16_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8u16_pkg::in_t    in_data,
  input  u8u16_pkg::q_stat_t q_stat,
  output logic              push,
  output u8u16_pkg::work_t  push_data
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [2:0]  len_r, len_nxt;

  logic            accept;
  logic [1:0]      cnt;
  logic [7:0]      b;
  logic            fin;
  logic            bad;
  logic [20:0]     cp;
  logic [20:0]     sup;
  u8u16_pkg::work_t w;

  function automatic u8u16_pkg::work_t put(input u8u16_pkg::work_t wi, input logic [1:0] n,
                                          input logic [15:0] unit, input logic err);
    u8u16_pkg::work_t wo;
    wo = wi;
    if (n == 2'd0) begin
      wo.r0.code_unit    = unit;
      wo.r0.bad_sequence = err;
    end else begin
      wo.r1.code_unit    = unit;
      wo.r1.bad_sequence = err;
    end
    return wo;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.text_byte;
  assign fin      = in_data.final_byte;
  assign cp       = {partial_r[14:0], b[5:0]};
  assign sup      = cp - u8u16_pkg::CP_SUPP_BASE;

  always_comb begin
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    len_nxt     = len_r;
    cnt         = 2'd0;
    bad         = 1'b0;
    w           = '0;
    if (pending_r != 2'd0 && b[7:6] == 2'b10) begin
      partial_nxt = cp;
      pending_nxt = pending_r - 2'd1;
      if (pending_nxt == 2'd0) begin
        if (len_r == u8u16_pkg::SEQ_LEN2 && cp < u8u16_pkg::CP_MIN2) begin
          bad = 1'b1;
        end
        if (len_r == u8u16_pkg::SEQ_LEN3 && (cp < u8u16_pkg::CP_MIN3 ||
            (cp >= u8u16_pkg::CP_SUR_LO && cp <= u8u16_pkg::CP_SUR_HI))) begin
          bad = 1'b1;
        end
        if (len_r == u8u16_pkg::SEQ_LEN4 &&
            (cp < u8u16_pkg::CP_MIN4 || cp > u8u16_pkg::CP_MAX)) begin
          bad = 1'b1;
        end
        partial_nxt = '0;
        len_nxt     = '0;
        if (bad) begin
          w = put(w, cnt, 16'h0000, 1'b1);
          cnt = cnt + 2'd1;
        end else if (cp[20:16] == 5'd0) begin
          w = put(w, cnt, cp[15:0], 1'b0);
          cnt = cnt + 2'd1;
        end else begin
          w = put(w, cnt, {u8u16_pkg::HI_SUR_TAG, sup[19:10]}, 1'b0);
          cnt = cnt + 2'd1;
          w = put(w, cnt, {u8u16_pkg::LO_SUR_TAG, sup[9:0]}, 1'b0);
          cnt = cnt + 2'd1;
        end
      end
    end else begin
      // broken sequence: report, then treat the byte as a lead
      if (pending_r != 2'd0) begin
        w = put(w, cnt, 16'h0000, 1'b1);
        cnt = cnt + 2'd1;
        partial_nxt = '0;
        pending_nxt = '0;
        len_nxt     = '0;
      end
      if (b[7] == 1'b0) begin
        w = put(w, cnt, {8'h00, b}, 1'b0);
        cnt = cnt + 2'd1;
      end else if (b[7:5] == 3'b110) begin
        partial_nxt = {16'h0000, b[4:0]};
        pending_nxt = 2'd1;
        len_nxt     = u8u16_pkg::SEQ_LEN2;
      end else if (b[7:4] == 4'b1110) begin
        partial_nxt = {17'h00000, b[3:0]};
        pending_nxt = 2'd2;
        len_nxt     = u8u16_pkg::SEQ_LEN3;
      end else if (b[7:3] == 5'b11110) begin
        partial_nxt = {18'h00000, b[2:0]};
        pending_nxt = 2'd3;
        len_nxt     = u8u16_pkg::SEQ_LEN4;
      end else begin
        w = put(w, cnt, 16'h0000, 1'b1);
        cnt = cnt + 2'd1;
      end
    end
    if (fin) begin
      // truncated text
      if (pending_nxt != 2'd0) begin
        w = put(w, cnt, 16'h0000, 1'b1);
        cnt = cnt + 2'd1;
      end
      partial_nxt = '0;
      pending_nxt = '0;
      len_nxt     = '0;
    end
    w.two = (cnt == 2'd2);
    if (cnt == 2'd2) begin
      w.r1.run_last  = 1'b1;
      w.r1.text_done = fin;
    end else begin
      w.r0.run_last  = 1'b1;
      w.r0.text_done = fin;
    end
  end

  assign push      = accept && (cnt != 2'd0);
  assign push_data = w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= '0;
      len_r     <= '0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

/* rtl/core/u8u16_fifo.sv */
module u8u16_fifo #(
  parameter int unsigned Depth = u8u16_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8u16_pkg::work_t   push_data,
  input  logic               pop,
  output u8u16_pkg::work_t   head,
  output u8u16_pkg::q_stat_t q_stat
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  u8u16_pkg::work_t mem [Depth];

  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt_r == Full);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head    = mem[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LastIdx) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LastIdx) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/u8u16_back.sv */
module u8u16_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8u16_pkg::work_t   head,
  input  u8u16_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8u16_pkg::out_t    out_data
);

  logic            sel_r, sel_nxt;
  logic            out_valid_r, out_valid_nxt;
  u8u16_pkg::out_t out_data_r, out_data_nxt;
  logic            take;

  // output register refills whenever it is empty or being drained and the queue holds an entry
  assign take = (!out_valid_r || out_ready) && !q_stat.empty;
  assign pop  = take && (sel_r || !head.two);

  always_comb begin
    sel_nxt       = sel_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sel_r ? head.r1 : head.r0;
      sel_nxt       = !sel_r && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/utf8_to_utf16_transcoder_top.sv */
// utf-8 to utf-16 transcoder
// in channel: one utf-8 byte per transfer (in_data.text_byte), with
// in_data.final_byte marking the last byte of a text
// out channel: utf-16 code units, one per transfer; an error result has
// bad_sequence set and a zero code unit; run_last flags the last result
// caused by a byte, text_done the last result of the final byte
// the decoder is combinational: a byte's results enter the queue at its
// transfer edge and the first one then moves into the output register
// throughput: one byte per cycle in while the queue is not full, one result
// per cycle out while out_ready is high; a byte with two results (surrogate
// pair, or error plus another result) is absorbed by the queue (FifoDepth entries)
// bytes that only open or extend a sequence produce no result
// reset clears the decoder state, the queue and the output register
// if the receiver stalls, the queue fills and in_ready drops once it is full
module utf8_to_utf16_transcoder_top #(
  parameter int unsigned FifoDepth = u8u16_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  u8u16_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output u8u16_pkg::out_t out_data
);

  u8u16_pkg::work_t   push_data;
  u8u16_pkg::work_t   head;
  u8u16_pkg::q_stat_t q_stat;
  logic               push;
  logic               pop;

  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  u8u16_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a high surrogate is always followed at once by its low half
  a_sur_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.bad_sequence &&
    out_data.code_unit[15:10] == u8u16_pkg::HI_SUR_TAG
    |=> out_valid && !out_data.bad_sequence &&
        out_data.code_unit[15:10] == u8u16_pkg::LO_SUR_TAG)
    else $error("high surrogate not followed by low surrogate");

  // no push is dropped on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push && !in_ready)
    else $error("push into full result queue");

  // a pop always hands the output register a result
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("queue popped without loading output");

endmodule
